FILE: rtl/core/dq_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Command and status codes, default sizes, field widths, and the control and
// status bundles that pass between the controller and the datapath.
// -----------------------------------------------------------------------------
package dq_pkg;

	// Default sizes of the ring.
	localparam int DEPTH_DEFAULT       = 256;
	localparam int VALUE_WIDTH_DEFAULT = 32;

	// Fixed widths of the channel fields.
	localparam int COMMAND_W = 3;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 9;

	// Command codes carried on the request channel.
	typedef enum logic [COMMAND_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_POP_BACK   = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_code_t;

	// Status codes reported with each result.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation that the datapath carries out.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH_BACK,
		OP_POP_BACK,
		OP_PUSH_FRONT,
		OP_POP_FRONT,
		OP_CLEAR
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		op_t     op;
		logic    status_we;
		status_t status;
		logic    fetch_front;
		logic    fetch_back;
		logic    load_out;
	} dq_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
	} dq_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/dq_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dq_if: request and result channels of the double-ended queue
// Valid/ready channels; a transfer happens on a clock edge where both are high.
// -----------------------------------------------------------------------------
interface dq_req_if;
	import dq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [COMMAND_W-1:0] command;
	logic [VALUE_W-1:0]   value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  front_value;
	logic [VALUE_W-1:0]  back_value;
	logic [COUNT_W-1:0]  entry_count;
	logic                is_empty;

	modport source (output valid, output status, output front_value, output back_value,
		output entry_count, output is_empty, input ready);
	modport sink   (input valid, input status, input front_value, input back_value,
		input entry_count, input is_empty, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dq_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dq_ctrl: controller of the double-ended queue
// Decodes each request against the full and empty flags, sequences the
// memory fetch that follows a pop, and owns the result valid flag.
// -----------------------------------------------------------------------------
module dq_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	input  wire logic [dq_pkg::COMMAND_W-1:0] req_command,
	output logic                              req_ready,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	input  wire dq_pkg::dq_stat_t             stat,
	output dq_pkg::dq_cmd_t                   cmd
);
	import dq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_HOLD
	} state_t;

	state_t  state_q;
	logic    fetch_front_q;
	logic    out_valid_q;

	logic    accept;
	logic    slot_free;
	logic    is_pop;
	op_t     op_dec;
	status_t status_dec;

	// Decode the command; a blocked push or pop turns into no operation.
	always_comb begin
		op_dec     = OP_NONE;
		status_dec = ST_DONE;
		case (req_command)
			CMD_PUSH_BACK: begin
				if (stat.full) status_dec = ST_FULL;
				else op_dec = OP_PUSH_BACK;
			end
			CMD_POP_BACK: begin
				if (stat.empty) status_dec = ST_EMPTY;
				else op_dec = OP_POP_BACK;
			end
			CMD_PUSH_FRONT: begin
				if (stat.full) status_dec = ST_FULL;
				else op_dec = OP_PUSH_FRONT;
			end
			CMD_POP_FRONT: begin
				if (stat.empty) status_dec = ST_EMPTY;
				else op_dec = OP_POP_FRONT;
			end
			CMD_CLEAR: begin
				op_dec = OP_CLEAR;
			end
			default: begin
				op_dec     = OP_NONE;
				status_dec = ST_DONE;
			end
		endcase
	end

	assign accept    = req_valid && (state_q == S_IDLE);
	assign slot_free = !out_valid_q || rsp_ready;
	assign is_pop    = (op_dec == OP_POP_BACK) || (op_dec == OP_POP_FRONT);

	// Commands to the datapath.
	always_comb begin
		cmd.op          = accept ? op_dec : OP_NONE;
		cmd.status_we   = accept;
		cmd.status      = status_dec;
		cmd.fetch_front = (state_q == S_FETCH) && fetch_front_q;
		cmd.fetch_back  = (state_q == S_FETCH) && !fetch_front_q;
		cmd.load_out    = slot_free && ((accept && !is_pop) || (state_q == S_FETCH) ||
			(state_q == S_HOLD));
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fetch_front_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_pop) begin
							state_q       <= S_FETCH;
							fetch_front_q <= (op_dec == OP_POP_FRONT);
						end else if (!slot_free) begin
							state_q <= S_HOLD;
						end
					end
				end
				S_FETCH, S_HOLD: begin
					state_q <= slot_free ? S_IDLE : S_HOLD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/dq_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dq_datapath: ring storage, pointers and result register
// Holds the entry memory, the front and back pointers, the entry count, a
// cached copy of the front and back values, and the registered result.
// -----------------------------------------------------------------------------
module dq_datapath #(
	parameter int DEPTH       = dq_pkg::DEPTH_DEFAULT,
	parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dq_pkg::dq_cmd_t             cmd,
	input  wire logic [dq_pkg::VALUE_W-1:0]  req_value,
	output dq_pkg::dq_stat_t                 stat,
	output logic [dq_pkg::STATUS_W-1:0]      rsp_status,
	output logic [dq_pkg::VALUE_W-1:0]       rsp_front_value,
	output logic [dq_pkg::VALUE_W-1:0]       rsp_back_value,
	output logic [dq_pkg::COUNT_W-1:0]       rsp_entry_count,
	output logic                             rsp_is_empty
);
	import dq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - 1'b1;
	endfunction

	logic [VALUE_WIDTH-1:0] entry_store_q [DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic [AW-1:0]          front_q, back_q;
	logic [CW-1:0]          count_q;
	logic [VALUE_WIDTH-1:0] front_val_q, back_val_q;
	status_t                status_q;

	logic [AW-1:0]          front_d, back_d;
	logic [CW-1:0]          count_d;
	logic [VALUE_WIDTH-1:0] front_val_d, back_val_d;
	status_t                status_d;
	logic                   empty_d;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic [VALUE_WIDTH-1:0] wr_data;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign wr_data    = VALUE_WIDTH'(req_value);

	// The value that becomes the new back or front after a pop.
	assign rd_addr = (cmd.op == OP_POP_BACK) ? ring_prev(ring_prev(back_q))
		: ring_next(front_q);

	// Next state of pointers, count and cached end values.
	always_comb begin
		front_d     = front_q;
		back_d      = back_q;
		count_d     = count_q;
		front_val_d = front_val_q;
		back_val_d  = back_val_q;
		wr_en       = 1'b0;
		wr_addr     = back_q;
		case (cmd.op)
			OP_PUSH_BACK: begin
				wr_en      = 1'b1;
				wr_addr    = back_q;
				back_d     = ring_next(back_q);
				count_d    = count_q + 1'b1;
				back_val_d = wr_data;
				if (stat.empty) front_val_d = wr_data;
			end
			OP_PUSH_FRONT: begin
				wr_en       = 1'b1;
				wr_addr     = ring_prev(front_q);
				front_d     = ring_prev(front_q);
				count_d     = count_q + 1'b1;
				front_val_d = wr_data;
				if (stat.empty) back_val_d = wr_data;
			end
			OP_POP_BACK: begin
				back_d  = ring_prev(back_q);
				count_d = count_q - 1'b1;
			end
			OP_POP_FRONT: begin
				front_d = ring_next(front_q);
				count_d = count_q - 1'b1;
			end
			OP_CLEAR: begin
				front_d = '0;
				back_d  = '0;
				count_d = '0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		if (cmd.fetch_front) front_val_d = rd_data_q;
		if (cmd.fetch_back)  back_val_d  = rd_data_q;
	end

	assign status_d = cmd.status_we ? cmd.status : status_q;
	assign empty_d  = (count_d == '0);

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) entry_store_q[wr_addr] <= wr_data;
		rd_data_q <= entry_store_q[rd_addr];
	end

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	// Cached end values, last status and the result register.
	always_ff @(posedge clk) begin
		front_val_q <= front_val_d;
		back_val_q  <= back_val_d;
		status_q    <= status_d;
		if (cmd.load_out) begin
			rsp_status      <= status_d;
			rsp_front_value <= empty_d ? '0 : VALUE_W'(front_val_d);
			rsp_back_value  <= empty_d ? '0 : VALUE_W'(back_val_d);
			rsp_entry_count <= COUNT_W'(count_d);
			rsp_is_empty    <= empty_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/double_ended_queue.sv
`default_nettype none
// -----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue on a ring buffer
// Push and pop at either end, or clear; every request yields one result with
// status, both end values, the entry count and an empty flag.
//
//   Channel  Dir  Payload
//   request  in   command[2:0], value[31:0]
//   result   out  status[1:0], front_value, back_value, entry_count[8:0], is_empty
//
// A push, clear, rejected request or unknown command goes straight to the result
// register; a pop that removes an entry first waits for the registered memory read
// of the new end value. A request is taken even while the previous result
// still waits; its own result is then held back, and no further request is
// taken, until the result register frees. Reset empties the queue at once;
// the entry memory is not cleared.
// -----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH       = dq_pkg::DEPTH_DEFAULT,
	parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dq_req_if.sink    request,
	dq_rsp_if.source  result
);
	import dq_pkg::*;

	dq_cmd_t  cmd;
	dq_stat_t stat;

	// Sequencing of each request.
	dq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (request.valid),
		.req_command (request.command),
		.req_ready   (request.ready),
		.rsp_valid   (result.valid),
		.rsp_ready   (result.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// Storage, pointers and result register.
	dq_datapath #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_value       (request.value),
		.stat            (stat),
		.rsp_status      (result.status),
		.rsp_front_value (result.front_value),
		.rsp_back_value  (result.back_value),
		.rsp_entry_count (result.entry_count),
		.rsp_is_empty    (result.is_empty)
	);

endmodule
`default_nettype wire

FILE: rtl/core/dq_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// dq_checker: port checks for the double-ended queue
// Watches the result channel for consistent fields and a held valid.
// -----------------------------------------------------------------------------
module dq_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [dq_pkg::VALUE_W-1:0]  rsp_front_value,
	input wire logic [dq_pkg::VALUE_W-1:0]  rsp_back_value,
	input wire logic [dq_pkg::COUNT_W-1:0]  rsp_entry_count,
	input wire logic                        rsp_is_empty
);
	import dq_pkg::*;

	// The empty flag agrees with the count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
		else $error("empty flag disagrees with entry count");

	// An empty queue shows zero at both ends.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_is_empty) |-> (rsp_front_value == '0 && rsp_back_value == '0))
		else $error("empty queue shows nonzero end values");

	// With one entry the front and the back are the same entry.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_entry_count == COUNT_W'(1)) |-> (rsp_front_value == rsp_back_value))
		else $error("single entry shows different front and back values");

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result withdrawn before transfer");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (result.valid),
	.rsp_ready       (result.ready),
	.rsp_front_value (result.front_value),
	.rsp_back_value  (result.back_value),
	.rsp_entry_count (result.entry_count),
	.rsp_is_empty    (result.is_empty)
);
`default_nettype wire
